### design/rycc_pkg.sv
// ----------------------------------------------------------------------------
// rycc_pkg - shared types and constants for the RGB / YCbCr converter
// Holds the pixel type and the Q2.14 coefficient tables for both directions.
// ----------------------------------------------------------------------------
package rycc_pkg;

	localparam int PIX_W   = 8;
	localparam int COEF_W  = 16;
	localparam int OPND_W  = PIX_W + 1;
	localparam int PROD_W  = OPND_W + COEF_W;
	localparam int SUM_W   = PROD_W + 2;
	localparam int FRAC_W  = 14;
	localparam int NCH     = 3;

	typedef logic [PIX_W-1:0]         pix_t;
	typedef logic signed [COEF_W-1:0] coef_t;
	typedef logic signed [OPND_W-1:0] opnd_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [SUM_W-1:0]  sum_t;

	localparam logic DIR_FWD = 1'b0;
	localparam logic DIR_INV = 1'b1;

	localparam logic signed [OPND_W-1:0] CHROMA_OFS = 9'sd128;
	localparam logic [FRAC_W-1:0]        ROUND_HALF = 14'd8192;

	// [direction][output channel][input component]
	localparam coef_t COEF [2][NCH][NCH] = '{
		'{  '{ 16'sd4899,   16'sd9617,   16'sd1868 },
		    '{-16'sd2764,  -16'sd5428,   16'sd8192 },
		    '{ 16'sd8192,  -16'sd6860,  -16'sd1332 } },
		'{  '{ 16'sd16384,  16'sd0,      16'sd22970 },
		    '{ 16'sd16384, -16'sd5638,  -16'sd11700 },
		    '{ 16'sd16384,  16'sd29032,  16'sd0 } }
	};

endpackage

### design/rycc_if.sv
// ----------------------------------------------------------------------------
// rycc_if - pixel stream interfaces
// Valid/ready channels for input pixels and converted pixels.
// ----------------------------------------------------------------------------
interface rycc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_c0;
	logic [7:0] in_c1;
	logic [7:0] in_c2;

	modport source (output valid, output in_c0, output in_c1, output in_c2, input ready);
	modport sink   (input valid, input in_c0, input in_c1, input in_c2, output ready);
endinterface

interface rycc_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_c0;
	logic [7:0] out_c1;
	logic [7:0] out_c2;

	modport source (output valid, output out_c0, output out_c1, output out_c2, input ready);
	modport sink   (input valid, input out_c0, input out_c1, input out_c2, output ready);
endinterface

### design/rgb_ycbcr_color_converter.sv
// ----------------------------------------------------------------------------
// rgb_ycbcr_color_converter - JFIF full-range RGB <-> YCbCr converter
// Three-stage pipeline: constant products, sums, round/offset/clamp.
// ----------------------------------------------------------------------------
// Usage:
//   in_pix  : sink channel, one pixel (c0, c1, c2) per beat.
//   out_pix : source channel, one converted pixel per input beat, in order.
//   cfg_we / cfg_wdata : writes the direction bit (0 = RGB to YCbCr,
//     1 = YCbCr to RGB). Write only while the pipeline is empty.
// Timing:
//   out_pix.valid rises once the beat has passed the stage 1 and stage 2
//   registers and is held in the stage 3 register.
//   Throughput is one pixel per clock while out_pix is not stalled; the nine
//   multiplies of stage 1 are 9 x 16 bit products, coefficients picked by direction.
// Reset:
//   arst_n clears all valid bits and sets the direction to forward.
// Stall:
//   Each stage holds while its successor is full and stalled; bubbles are
//   squeezed out, so in_pix.ready stays high until all three stages are
//   occupied and out_pix.ready is low. No beat is lost or repeated.
// ----------------------------------------------------------------------------
module rgb_ycbcr_color_converter
	import rycc_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic         cfg_wdata,
	rycc_in_if.sink      in_pix,
	rycc_out_if.source   out_pix
);

	logic dir_q;

	logic  v_s1, v_s2, v_s3;
	logic  dir_s1, dir_s2;
	prod_t prod_s1 [NCH][NCH];
	sum_t  sum_s2  [NCH];
	pix_t  res_s3  [NCH];

	logic adv1, adv2, adv3;

	assign adv3 = !v_s3 || out_pix.ready;
	assign adv2 = !v_s2 || adv3;
	assign adv1 = !v_s1 || adv2;

	assign in_pix.ready = adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q <= DIR_FWD;
		end else if (cfg_we) begin
			dir_q <= cfg_wdata;
		end
	end

	// stage 1 operands: chroma is recentered in inverse mode
	opnd_t opnd [NCH];
	prod_t prod [NCH][NCH];

	always_comb begin
		opnd[0] = $signed({1'b0, in_pix.in_c0});
		opnd[1] = $signed({1'b0, in_pix.in_c1});
		opnd[2] = $signed({1'b0, in_pix.in_c2});
		if (dir_q == DIR_INV) begin
			opnd[1] = opnd[1] - CHROMA_OFS;
			opnd[2] = opnd[2] - CHROMA_OFS;
		end
		for (int ch = 0; ch < NCH; ch++) begin
			for (int k = 0; k < NCH; k++) begin
				prod[ch][k] = prod_t'(opnd[k]) * prod_t'(COEF[dir_q][ch][k]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= in_pix.valid;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			dir_s1  <= dir_q;
			prod_s1 <= prod;
		end
	end

	always_ff @(posedge clk) begin
		if (adv2) begin
			dir_s2 <= dir_s1;
			for (int ch = 0; ch < NCH; ch++) begin
				sum_s2[ch] <= SUM_W'(prod_s1[ch][0]) + SUM_W'(prod_s1[ch][1])
				              + SUM_W'(prod_s1[ch][2]);
			end
		end
	end

	// stage 3: round half away from zero, add chroma offset (forward mode only), saturate
	localparam int Q_W = SUM_W - FRAC_W;

	logic [SUM_W-1:0]     mag   [NCH];
	logic [SUM_W-1:0]     rnd   [NCH];
	logic signed [Q_W+1:0] qv   [NCH];
	pix_t                 clamp [NCH];

	always_comb begin
		for (int ch = 0; ch < NCH; ch++) begin
			mag[ch] = sum_s2[ch][SUM_W-1] ? SUM_W'(-sum_s2[ch]) : SUM_W'(sum_s2[ch]);
			rnd[ch] = (mag[ch] + SUM_W'(ROUND_HALF)) >> FRAC_W;
			qv[ch]  = $signed({2'b00, rnd[ch][Q_W-1:0]});
			if (sum_s2[ch][SUM_W-1]) qv[ch] = -qv[ch];
			if (dir_s2 == DIR_FWD && ch != 0) qv[ch] = qv[ch] + (Q_W+2)'(CHROMA_OFS);
			if (qv[ch] < 0) begin
				clamp[ch] = '0;
			end else if (qv[ch] > (Q_W+2)'(255)) begin
				clamp[ch] = '1;
			end else begin
				clamp[ch] = qv[ch][PIX_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv3) begin
			res_s3 <= clamp;
		end
	end

	assign out_pix.valid  = v_s3;
	assign out_pix.out_c0 = res_s3[0];
	assign out_pix.out_c1 = res_s3[1];
	assign out_pix.out_c2 = res_s3[2];

endmodule

### bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top - testbench for rgb_ycbcr_color_converter
// Streams pixels in both directions, checks every converted beat against a
// built-in fixed-point predictor, with random sender bursts/gaps and
// receiver stall patterns.
// ----------------------------------------------------------------------------
module tb_top
	import rycc_pkg::*;
();

	localparam int PIPE_LAT    = 3;
	localparam int CHROMA_MID  = 128;
	localparam int MAX_PRINTS  = 40;

	typedef struct packed {
		pix_t c0;
		pix_t c1;
		pix_t c2;
	} pixel_t;

	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_RANDOM,
		STALL_PERIODIC,
		STALL_HEAVY
	} stall_mode_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;

	rycc_in_if  in_pix ();
	rycc_out_if out_pix ();

	rgb_ycbcr_color_converter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_pix    (in_pix),
		.out_pix   (out_pix)
	);

	pixel_t      expected_q [$];
	logic        dir_now;
	stall_mode_t stall_mode;
	int unsigned stall_tick = 0;
	int          burst_left;
	int          gap_max;
	logic        sending_on;
	int          error_count;
	int          fwd_count;
	int          inv_count;
	int          out_count;
	int          dir_writes;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("Timeout with %0d beats still expected", expected_q.size());
		$display("[rgb_ycbcr_color_converter] ERROR");
		$finish;
	end

	// --- predictor ----------------------------------------------------------

	// round half away from zero at bit 14
	function automatic int round_q14(int s);
		if (s >= 0)
			return (s + 8192) >>> 14;
		return -((-s + 8192) >>> 14);
	endfunction

	function automatic pix_t sat8(int v);
		if (v < 0)
			return '0;
		if (v > 255)
			return 8'd255;
		return pix_t'(v);
	endfunction

	function automatic pixel_t convert_pixel(logic dir, pixel_t px);
		int     a;
		int     b;
		int     c;
		pixel_t r;
		a = int'(px.c0);
		b = int'(px.c1);
		c = int'(px.c2);
		if (dir == DIR_FWD) begin
			r.c0 = sat8(round_q14(4899 * a + 9617 * b + 1868 * c));
			r.c1 = sat8(round_q14(-2764 * a - 5428 * b + 8192 * c) + CHROMA_MID);
			r.c2 = sat8(round_q14(8192 * a - 6860 * b - 1332 * c) + CHROMA_MID);
		end else begin
			b = b - CHROMA_MID;
			c = c - CHROMA_MID;
			r.c0 = sat8(round_q14(a * 16384 + 22970 * c));
			r.c1 = sat8(round_q14(a * 16384 - 5638 * b - 11700 * c));
			r.c2 = sat8(round_q14(a * 16384 + 29032 * b));
		end
		return r;
	endfunction

	// --- checking -----------------------------------------------------------

	task automatic report_mismatch(string what, pix_t got, pix_t want);
		if (error_count < MAX_PRINTS)
			$display("%0t: beat %0d %s got %0d expected %0d", $realtime, out_count,
				what, got, want);
		error_count++;
	endtask

	task automatic check_pixel(pixel_t got);
		pixel_t want;
		if (expected_q.size() == 0) begin
			report_mismatch("unexpected beat, c0", got.c0, '0);
		end else begin
			want = expected_q.pop_front();
			if (got.c0 !== want.c0)
				report_mismatch("c0", got.c0, want.c0);
			if (got.c1 !== want.c1)
				report_mismatch("c1", got.c1, want.c1);
			if (got.c2 !== want.c2)
				report_mismatch("c2", got.c2, want.c2);
		end
		out_count++;
	endtask

	// receiver: checks accepted beats, then picks ready for the next edge
	always @(posedge clk) begin
		if (arst_n && out_pix.valid && out_pix.ready)
			check_pixel({out_pix.out_c0, out_pix.out_c1, out_pix.out_c2});
		stall_tick <= stall_tick + 1;
		case (stall_mode)
			STALL_NONE:     out_pix.ready <= 1'b1;
			STALL_RANDOM:   out_pix.ready <= 1'($urandom_range(0, 1));
			STALL_PERIODIC: out_pix.ready <= ((stall_tick % 11) < 6);
			default:        out_pix.ready <= ($urandom_range(0, 3) == 0);
		endcase
	end

	// --- stimulus helpers ---------------------------------------------------

	task automatic send_pixel(pixel_t px);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
			if (gap > 0) begin
				in_pix.valid <= 1'b0;
				in_pix.in_c0 <= 8'($urandom);
				in_pix.in_c1 <= 8'($urandom);
				in_pix.in_c2 <= 8'($urandom);
				sending_on = 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		in_pix.valid <= 1'b1;
		in_pix.in_c0 <= px.c0;
		in_pix.in_c1 <= px.c1;
		in_pix.in_c2 <= px.c2;
		sending_on = 1'b1;
		@(posedge clk);
		while (!in_pix.ready)
			@(posedge clk);
		burst_left--;
		expected_q.push_back(convert_pixel(dir_now, px));
		if (dir_now == DIR_FWD)
			fwd_count++;
		else
			inv_count++;
	endtask

	task automatic idle_input();
		if (sending_on) begin
			in_pix.valid <= 1'b0;
			sending_on = 1'b0;
		end
		burst_left = 0;
	endtask

	task automatic wait_drained(int settle);
		@(posedge clk);
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic set_direction(logic d);
		idle_input();
		wait_drained(PIPE_LAT);
		cfg_we    <= 1'b1;
		cfg_wdata <= d;
		@(posedge clk);
		cfg_we    <= 1'b0;
		dir_now = d;
		dir_writes++;
	endtask

	function automatic pix_t random_level();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return 8'd255;
			2:       return pix_t'($urandom_range(CHROMA_MID - 3, CHROMA_MID + 3));
			3:       return pix_t'($urandom_range(0, 7));
			4:       return pix_t'($urandom_range(248, 255));
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic pixel_t random_pixel();
		pixel_t px;
		px.c0 = random_level();
		px.c1 = random_level();
		px.c2 = random_level();
		return px;
	endfunction

	// --- tests --------------------------------------------------------------

	task automatic test_forward_extremes();
		pixel_t pts [10];
		pts = '{
			'{8'd0,   8'd0,   8'd0  }, '{8'd255, 8'd255, 8'd255},
			'{8'd255, 8'd0,   8'd0  }, '{8'd0,   8'd255, 8'd0  },
			'{8'd0,   8'd0,   8'd255}, '{8'd255, 8'd0,   8'd255},
			'{8'd0,   8'd255, 8'd255}, '{8'd255, 8'd255, 8'd0  },
			'{8'd128, 8'd128, 8'd128}, '{8'd1,   8'd254, 8'd127}
		};
		stall_mode = STALL_NONE;
		gap_max = 0;
		set_direction(DIR_FWD);
		foreach (pts[i])
			send_pixel(pts[i]);
	endtask

	task automatic test_inverse_extremes();
		pixel_t pts [12];
		// mostly saturating corners: full chroma swings at black, mid and white luma
		pts = '{
			'{8'd0,   8'd128, 8'd128}, '{8'd255, 8'd128, 8'd128},
			'{8'd0,   8'd0,   8'd0  }, '{8'd255, 8'd255, 8'd255},
			'{8'd0,   8'd255, 8'd255}, '{8'd255, 8'd0,   8'd0  },
			'{8'd128, 8'd0,   8'd255}, '{8'd128, 8'd255, 8'd0  },
			'{8'd0,   8'd0,   8'd255}, '{8'd255, 8'd255, 8'd0  },
			'{8'd16,  8'd127, 8'd129}, '{8'd235, 8'd1,   8'd254}
		};
		stall_mode = STALL_RANDOM;
		gap_max = 2;
		set_direction(DIR_INV);
		foreach (pts[i])
			send_pixel(pts[i]);
	endtask

	task automatic test_random_stream();
		logic        dirs  [8] = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};
		int          gaps  [8] = '{0, 2, 6, 0, 4, 1, 8, 3};
		stall_mode_t modes [4] = '{STALL_NONE, STALL_RANDOM, STALL_PERIODIC, STALL_HEAVY};
		foreach (dirs[p]) begin
			set_direction(dirs[p]);
			stall_mode = modes[p % 4];
			gap_max = gaps[p];
			repeat (175)
				send_pixel(random_pixel());
		end
	endtask

	// hold the sender until the pipe is empty, then resume under stalls
	task automatic test_pause_until_empty();
		stall_mode = STALL_HEAVY;
		gap_max = 0;
		repeat (15)
			send_pixel(random_pixel());
		idle_input();
		wait_drained(0);
		stall_mode = STALL_PERIODIC;
		gap_max = 3;
		repeat (15)
			send_pixel(random_pixel());
	endtask

	initial begin
		arst_n        <= 1'b0;
		cfg_we        <= 1'b0;
		cfg_wdata     <= 1'b0;
		in_pix.valid  <= 1'b0;
		in_pix.in_c0  <= '0;
		in_pix.in_c1  <= '0;
		in_pix.in_c2  <= '0;
		stall_mode  = STALL_NONE;
		dir_now     = DIR_FWD;
		burst_left  = 0;
		gap_max     = 0;
		sending_on  = 1'b0;
		error_count = 0;
		fwd_count   = 0;
		inv_count   = 0;
		out_count   = 0;
		dir_writes  = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_forward_extremes();
		test_inverse_extremes();
		test_random_stream();
		test_pause_until_empty();

		idle_input();
		wait_drained(PIPE_LAT + 4);
		$display("Converted %0d pixels: %0d RGB->YCbCr, %0d YCbCr->RGB, %0d direction writes",
			out_count, fwd_count, inv_count, dir_writes);
		$display("Mismatches: %0d", error_count);
		if (error_count == 0)
			$display("[rgb_ycbcr_color_converter] OK");
		else
			$display("[rgb_ycbcr_color_converter] ERROR");
		$finish;
	end

endmodule

### rgb_ycbcr_color_converter.f
design/rycc_pkg.sv
design/rycc_if.sv
design/rgb_ycbcr_color_converter.sv
bench/tb_top.sv
